FILE: sv/pwmt_pkg.sv
// pwmt_pkg: shared types, register map and codes of the pwm timer
package pwmt_pkg;

  // request codes of an input transaction
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  // word indexes of the register map
  localparam logic [4:0] IDX_CTRL     = 5'd0;
  localparam logic [4:0] IDX_STATUS   = 5'd4;
  localparam logic [4:0] IDX_EVENT    = 5'd5;
  localparam logic [4:0] IDX_MODE_A   = 5'd6;
  localparam logic [4:0] IDX_MODE_B   = 5'd7;
  localparam logic [4:0] IDX_ENABLE   = 5'd8;
  localparam logic [4:0] IDX_COUNT    = 5'd9;
  localparam logic [4:0] IDX_PRESCALE = 5'd10;
  localparam logic [4:0] IDX_RELOAD   = 5'd11;
  localparam logic [4:0] IDX_CMP_BASE = 5'd13;

  // pwm mode fields of the low and high channel of a mode register
  localparam logic [15:0] MODE_LO_FIELD = 16'(6 << 4);
  localparam logic [15:0] MODE_HI_FIELD = 16'(6 << 12);

  typedef enum logic [2:0] {
    MODE_FROZEN     = 3'd0,
    MODE_SET_MATCH  = 3'd1,
    MODE_CLR_MATCH  = 3'd2,
    MODE_TOG_MATCH  = 3'd3,
    MODE_FORCE_LOW  = 3'd4,
    MODE_FORCE_HIGH = 3'd5,
    MODE_PWM1       = 3'd6,
    MODE_PWM2       = 3'd7
  } chan_mode_t;

  // per-channel control from the core to a channel output stage
  typedef struct packed {
    logic       fire;
    logic       match;
    chan_mode_t mode;
    logic       is_input;
    logic       en;
    logic       pol;
  } chan_ctl_t;

  function automatic chan_mode_t mode_of(input logic [15:0] r, input logic hi);
    return hi ? chan_mode_t'(r[14:12]) : chan_mode_t'(r[6:4]);
  endfunction

  function automatic logic preload_of(input logic [15:0] r, input logic hi);
    return hi ? r[11] : r[3];
  endfunction

  function automatic logic input_of(input logic [15:0] r, input logic hi);
    return hi ? (r[9:8] != 2'b00) : (r[1:0] != 2'b00);
  endfunction

  // true when the mode register holds pwm mode 1 for that channel
  function automatic logic is_pwm1(input logic [15:0] r, input logic hi);
    return hi ? ((r & MODE_HI_FIELD) == MODE_HI_FIELD && !r[12])
              : ((r & MODE_LO_FIELD) == MODE_LO_FIELD && !r[4]);
  endfunction

endpackage

FILE: sv/pwmt_ifs.sv
// pwmt_ifs: request and response channel interfaces of the pwm timer
interface pwmt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  reg_index;
  logic [15:0] write_data;

  modport source (output valid, output req_type, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input reg_index, input write_data,
                output ready);
endinterface

interface pwmt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [3:0]  pwm_out;
  logic [3:0]  compare_flags;
  logic        update_flag;

  modport source (output valid, output read_data, output pwm_out, output compare_flags,
                  output update_flag, input ready);
  modport sink (input valid, input read_data, input pwm_out, input compare_flags,
                input update_flag, output ready);
endinterface

FILE: sv/pwm_timer_peripheral_unit.sv
// pwm_timer_peripheral_unit: top level of the four-channel pwm timer
// a request is taken into the request register, then its result into the result register
// throughput: one transaction per cycle unless the result stalls; the whole state update
//   of a request is a single pass from the request register into state and result registers
// reset: synchronous rst clears all timer registers, reload to full scale,
//   and empties the request and result registers
module pwm_timer_peripheral_unit
  import pwmt_pkg::*;
#(
  parameter int COUNT_WIDTH  = 16,
  parameter int NUM_CHANNELS = 4
) (
  input logic       clk,
  input logic       rst,
  pwmt_req_if.sink  req,
  pwmt_rsp_if.source rsp
);

  // request register
  logic        in_v;
  logic [1:0]  in_type;
  logic [4:0]  in_index;
  logic [15:0] in_data;

  // result register
  logic        out_v;
  logic [15:0] out_rd;
  logic [3:0]  out_pwm;
  logic [3:0]  out_cmp;
  logic        out_upd;

  // a request fires when the result register is free or being drained
  logic advance;
  logic fire;

  logic [15:0]            rd_next;
  logic [4:0]             status_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] cmp_next [NUM_CHANNELS];
  chan_ctl_t              ctl [NUM_CHANNELS];
  logic [3:0]             pwm_next;

  assign advance   = !out_v || rsp.ready;
  assign fire      = in_v && advance;
  assign req.ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (req.ready) begin
      in_v <= req.valid;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_type  <= req.req_type;
      in_index <= req.reg_index;
      in_data  <= req.write_data;
    end
  end

  pwmt_core #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (in_type),
    .reg_index  (in_index),
    .write_data (in_data),
    .rd_next    (rd_next),
    .status_out (status_next),
    .count_out  (count_next),
    .cmp_out    (cmp_next),
    .ctl        (ctl)
  );

  // one output stage per fitted channel; missing channels drive low
  for (genvar c = 0; c < 4; c++) begin : g_chan
    if (c < NUM_CHANNELS) begin : g_used
      pwmt_chan #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_chan (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl[c]),
        .count (count_next),
        .cmp   (cmp_next[c]),
        .pin   (pwm_next[c])
      );
    end else begin : g_unused
      assign pwm_next[c] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= in_v;
    end
  end

  // result payload, shows the state after the transaction
  always_ff @(posedge clk) begin
    if (fire) begin
      out_rd  <= rd_next;
      out_pwm <= pwm_next;
      out_cmp <= status_next[4:1];
      out_upd <= status_next[0];
    end
  end

  assign rsp.valid         = out_v;
  assign rsp.read_data     = out_rd;
  assign rsp.pwm_out       = out_pwm;
  assign rsp.compare_flags = out_cmp;
  assign rsp.update_flag   = out_upd;

  // a request that cannot fire stays in the request register
  a_hold_req: assert property (@(posedge clk) disable iff (rst) in_v && !advance |=> in_v)
    else $error("request dropped while result stalled");

  // every fired request gives a result in the next cycle
  a_fire_result: assert property (@(posedge clk) disable iff (rst) fire |=> rsp.valid)
    else $error("fired request without result");

  // an empty request register always takes a new transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst) !in_v |-> req.ready)
    else $error("request register empty but not ready");

endmodule

FILE: sv/pwmt_chan.sv
// pwmt_chan: reference level and output pin of one compare channel
module pwmt_chan
  import pwmt_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  chan_ctl_t              ctl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [COUNT_WIDTH-1:0] cmp,
  output logic                   pin
);

  logic level;
  logic level_next;

  always_comb begin
    level_next = level;
    if (ctl.is_input) begin
      level_next = 1'b0;
    end else begin
      case (ctl.mode)
        MODE_SET_MATCH: begin
          if (ctl.match) level_next = 1'b1;
        end
        MODE_CLR_MATCH: begin
          if (ctl.match) level_next = 1'b0;
        end
        MODE_TOG_MATCH: begin
          if (ctl.match) level_next = ~level;
        end
        MODE_FORCE_LOW:  level_next = 1'b0;
        MODE_FORCE_HIGH: level_next = 1'b1;
        MODE_PWM1:       level_next = (count < cmp);
        MODE_PWM2:       level_next = (count >= cmp);
        default:         level_next = level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
    end else if (ctl.fire) begin
      level <= level_next;
    end
  end

  assign pin = ctl.en ? (level_next ^ ctl.pol) : 1'b0;

endmodule

FILE: sv/pwmt_core.sv
// pwmt_core: register file, prescaler, counter, update and compare logic
module pwmt_core
  import pwmt_pkg::*;
#(
  parameter int COUNT_WIDTH  = 16,
  parameter int NUM_CHANNELS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [1:0]             req_type,
  input  logic [4:0]             reg_index,
  input  logic [15:0]            write_data,
  output logic [15:0]            rd_next,
  output logic [4:0]             status_out,
  output logic [COUNT_WIDTH-1:0] count_out,
  output logic [COUNT_WIDTH-1:0] cmp_out [NUM_CHANNELS],
  output chan_ctl_t              ctl [NUM_CHANNELS]
);

  logic [1:0]             ctrl, ctrl_next;
  logic [4:0]             status, status_next;
  logic [15:0]            modes [2];
  logic [15:0]            modes_next [2];
  logic [15:0]            enables, enables_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [15:0]            psc_pre, psc_pre_next;
  logic [15:0]            psc_act, psc_act_next;
  logic [15:0]            psc_cnt, psc_cnt_next;
  logic [COUNT_WIDTH-1:0] rel_pre, rel_pre_next;
  logic [COUNT_WIDTH-1:0] rel_act, rel_act_next;
  logic [COUNT_WIDTH-1:0] cmp_pre [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] cmp_pre_next [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] cmp_act [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] cmp_act_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] match;
  logic                   adv;
  logic                   upd;
  logic [COUNT_WIDTH-1:0] wdata_cnt;

  assign wdata_cnt = COUNT_WIDTH'(write_data);

  // next state of one transaction
  always_comb begin
    ctrl_next    = ctrl;
    status_next  = status;
    modes_next   = modes;
    enables_next = enables;
    count_next   = count;
    psc_pre_next = psc_pre;
    psc_act_next = psc_act;
    psc_cnt_next = psc_cnt;
    rel_pre_next = rel_pre;
    rel_act_next = rel_act;
    cmp_pre_next = cmp_pre;
    cmp_act_next = cmp_act;
    adv   = 1'b0;
    upd   = 1'b0;
    match = '0;

    case (req_type_t'(req_type))
      REQ_TICK: begin
        if (ctrl[0]) begin
          if (psc_cnt < psc_act) begin
            psc_cnt_next = psc_cnt + 16'd1;
          end else begin
            psc_cnt_next = '0;
            adv = 1'b1;
            if (count == rel_act) begin
              count_next = '0;
              upd = 1'b1;
            end else begin
              count_next = count + COUNT_WIDTH'(1);
            end
          end
        end
      end
      REQ_WRITE: begin
        case (reg_index)
          IDX_CTRL:     ctrl_next = {write_data[7], write_data[0]};
          IDX_STATUS:   status_next = status & write_data[4:0];
          IDX_EVENT: begin
            if (write_data[0]) begin
              count_next   = '0;
              psc_cnt_next = '0;
              upd = 1'b1;
            end
            status_next[4:1] = status[4:1] | write_data[4:1];
          end
          IDX_MODE_A:   modes_next[0] = write_data;
          IDX_MODE_B:   modes_next[1] = write_data;
          IDX_ENABLE:   enables_next = write_data;
          IDX_COUNT:    count_next = wdata_cnt;
          IDX_PRESCALE: psc_pre_next = write_data;
          IDX_RELOAD: begin
            rel_pre_next = wdata_cnt;
            if (!ctrl[1]) rel_act_next = wdata_cnt;
          end
          default: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (reg_index == IDX_CMP_BASE + 5'(c)) begin
                cmp_pre_next[c] = wdata_cnt;
                if (!preload_of(modes[1'(c >> 1)], 1'(c))) cmp_act_next[c] = wdata_cnt;
              end
            end
          end
        endcase
      end
      default: ;
    endcase

    // update event: shadows load, update flag set
    if (upd) begin
      psc_act_next = psc_pre;
      rel_act_next = rel_pre;
      cmp_act_next = cmp_pre;
      status_next[0] = 1'b1;
    end

    // compares only on a counter advance
    if (adv) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        match[c] = !input_of(modes_next[1'(c >> 1)], 1'(c)) && (count_next == cmp_act_next[c]);
        if (match[c]) status_next[c+1] = 1'b1;
      end
    end
  end

  // register read
  always_comb begin
    rd_next = '0;
    if (req_type_t'(req_type) == REQ_READ) begin
      case (reg_index)
        IDX_CTRL:     rd_next = {8'h00, ctrl[1], 6'h00, ctrl[0]};
        IDX_STATUS:   rd_next = {11'h000, status};
        IDX_MODE_A:   rd_next = modes[0];
        IDX_MODE_B:   rd_next = modes[1];
        IDX_ENABLE:   rd_next = enables;
        IDX_COUNT:    rd_next = 16'(count);
        IDX_PRESCALE: rd_next = psc_pre;
        IDX_RELOAD:   rd_next = 16'(rel_pre);
        default: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (reg_index == IDX_CMP_BASE + 5'(c)) rd_next = 16'(cmp_pre[c]);
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      ctl[c].fire     = fire;
      ctl[c].match    = match[c];
      ctl[c].mode     = mode_of(modes_next[1'(c >> 1)], 1'(c));
      ctl[c].is_input = input_of(modes_next[1'(c >> 1)], 1'(c));
      ctl[c].en       = enables_next[4*c];
      ctl[c].pol      = enables_next[4*c+1];
    end
  end

  assign status_out = status_next;
  assign count_out  = count_next;
  assign cmp_out    = cmp_act_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl     <= '0;
      status   <= '0;
      modes[0] <= '0;
      modes[1] <= '0;
      enables  <= '0;
      count    <= '0;
      psc_pre  <= '0;
      psc_act  <= '0;
      psc_cnt  <= '0;
      rel_pre  <= '1;
      rel_act  <= '1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cmp_pre[c] <= '0;
        cmp_act[c] <= '0;
      end
    end else if (fire) begin
      ctrl    <= ctrl_next;
      status  <= status_next;
      modes   <= modes_next;
      enables <= enables_next;
      count   <= count_next;
      psc_pre <= psc_pre_next;
      psc_act <= psc_act_next;
      psc_cnt <= psc_cnt_next;
      rel_pre <= rel_pre_next;
      rel_act <= rel_act_next;
      cmp_pre <= cmp_pre_next;
      cmp_act <= cmp_act_next;
    end
  end

  // prescaler counter never passes its active limit
  a_psc_bound: assert property (@(posedge clk) disable iff (rst) psc_cnt <= psc_act)
    else $error("prescaler counter above active prescale");

  // a wrap on a prescaled tick clears the counter and raises the update flag
  a_wrap_update: assert property (@(posedge clk) disable iff (rst)
    fire && req_type_t'(req_type) == REQ_TICK && ctrl[0] && psc_cnt == psc_act
      && count == rel_act |=> status[0] && count == '0)
    else $error("counter wrap without update event");

endmodule
